// ----- src/ifp_pkg.sv -----
package ifp_pkg;

  localparam int MAX_FLOWS = 16;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_EMIT = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] REG_WIN_BEGIN = 2'd0;
  localparam logic [1:0] REG_WIN_END   = 2'd1;
  localparam logic [1:0] REG_STEP      = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] flow_start;
    logic [31:0] flow_stop;
    logic [15:0] flow_total;
    logic [31:0] tick_time;
  } cmd_t;

  typedef struct packed {
    logic [31:0] window_begin;
    logic [31:0] window_end;
    logic [15:0] step_length;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_TICK, ST_NEXT, ST_RD, ST_CHK,
    ST_DIV1, ST_DIV2, ST_MUL, ST_CMP, ST_DONE
  } state_t;

endpackage

// ----- src/ifp_front.sv -----
module ifp_front import ifp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  cmd_t in_cmd,
  output logic busy,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, do_pop;

  // two-beat queue toward the back part
  assign busy    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rp_r];
  assign push    = start && !busy;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wp_nxt  = push   ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= in_cmd;
  end

endmodule

// ----- src/ifp_div.sv -----
module ifp_div import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  assign done     = done_r;
  assign quotient = quo_r;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) dvs_r <= divisor;
  end

endmodule

// ----- src/ifp_back.sv -----
module ifp_back import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_flow_index,
  output logic [15:0] out_first_sequence,
  output logic [15:0] out_event_count,
  output logic        out_all_done,
  output logic        out_accepted,
  output logic        out_last
);

  // flow table
  logic [31:0] fs_mem [MAX_FLOWS];
  logic [31:0] fe_mem [MAX_FLOWS];
  logic [15:0] tot_mem [MAX_FLOWS];
  logic [15:0] iss_mem [MAX_FLOWS];

  state_t      st_r, st_nxt;
  cmd_t        cmd_r;
  logic [CNT_W-1:0] loaded_r, idx_r;
  logic        ended_r;
  logic [31:0] fs_r, fe_r, dur_r;
  logic [15:0] tot_r, iss_r, base_r;
  logic [32:0] plo_r, phi_r;
  logic [48:0] rp_r;
  logic [15:0] step;
  logic        in_win, load_ok, active;
  logic        div_go, div_done;
  logic [31:0] div_a, div_b, div_q, steps;
  logic [16:0] after, cnt;
  logic [33:0] d2;
  logic [49:0] lhs, rhs;
  logic [17:0] newiss;
  logic [15:0] newiss_sat, cnt_sat;

  assign step    = (cfg.step_length == 16'd0) ? 16'd1 : cfg.step_length;
  assign in_win  = (cmd_r.tick_time >= cfg.window_begin) &&
                   (cmd_r.tick_time < cfg.window_end);
  assign load_ok = (loaded_r < CNT_W'(MAX_FLOWS)) &&
                   (cmd_r.flow_stop > cmd_r.flow_start) &&
                   (cmd_r.flow_stop >= cfg.window_begin);
  assign active  = (fs_r <= cmd_r.tick_time) && (cmd_r.tick_time < fe_r);
  assign steps   = (div_q == 32'd0) ? 32'd1 : div_q;
  assign pop     = (st_r == ST_IDLE) && q_valid;

  // emission arithmetic
  always_comb begin
    after      = {1'b0, iss_r} + {1'b0, base_r};
    d2         = {1'b0, cmd_r.tick_time - fs_r, 1'b0} + {18'd0, step};
    lhs        = {17'd0, plo_r} + {phi_r, 17'd0};
    rhs        = {rp_r, 1'b0};
    cnt        = {1'b0, base_r} + {16'd0, (lhs > rhs)};
    newiss     = {2'b0, iss_r} + {1'b0, cnt};
    newiss_sat = (newiss > 18'd65535) ? 16'hFFFF : newiss[15:0];
    cnt_sat    = cnt[16] ? 16'hFFFF : cnt[15:0];
  end

  ifp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (q_valid) st_nxt = (q_cmd.action == ACT_LOAD) ? ST_LOAD : ST_TICK;
      ST_LOAD: st_nxt = ST_IDLE;
      ST_TICK: st_nxt = in_win ? ST_NEXT : ST_DONE;
      ST_NEXT: st_nxt = (idx_r >= loaded_r) ? ST_DONE : ST_RD;
      ST_RD:   st_nxt = ST_CHK;
      ST_CHK:  st_nxt = active ? ST_DIV1 : ST_NEXT;
      ST_DIV1: if (div_done) st_nxt = ST_DIV2;
      ST_DIV2: if (div_done) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_CMP;
      ST_CMP:  st_nxt = ST_NEXT;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // divider control
  always_comb begin
    div_go = 1'b0;
    div_a  = fe_r - fs_r;
    div_b  = {16'd0, step};
    unique case (st_r)
      ST_CHK:  div_go = active;
      ST_DIV1: begin
        div_go = div_done;
        div_a  = {16'd0, tot_r};
        div_b  = steps;
      end
      default: div_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      loaded_r   <= '0;
      ended_r    <= 1'b0;
      idx_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      out_strobe <= (st_r == ST_LOAD) || (st_r == ST_CMP) || (st_r == ST_DONE);
      if (st_r == ST_LOAD && load_ok) loaded_r <= loaded_r + CNT_W'(1);
      if (st_r == ST_TICK) begin
        idx_r <= '0;
        if (in_win) ended_r <= 1'b1;
      end
      if (st_r == ST_CHK) begin
        if (fe_r > cmd_r.tick_time) ended_r <= 1'b0;
        if (!active) idx_r <= idx_r + CNT_W'(1);
      end
      if (st_r == ST_CMP) idx_r <= idx_r + CNT_W'(1);
    end
  end

  // datapath registers and table access
  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_cmd;
    if (st_r == ST_LOAD && load_ok) begin
      fs_mem[loaded_r[IDX_W-1:0]]  <= cmd_r.flow_start;
      fe_mem[loaded_r[IDX_W-1:0]]  <= cmd_r.flow_stop;
      tot_mem[loaded_r[IDX_W-1:0]] <= cmd_r.flow_total;
      iss_mem[loaded_r[IDX_W-1:0]] <= 16'd0;
    end else if (st_r == ST_CMP) begin
      iss_mem[idx_r[IDX_W-1:0]] <= newiss_sat;
    end
    if (st_r == ST_RD) begin
      fs_r  <= fs_mem[idx_r[IDX_W-1:0]];
      fe_r  <= fe_mem[idx_r[IDX_W-1:0]];
      tot_r <= tot_mem[idx_r[IDX_W-1:0]];
      iss_r <= iss_mem[idx_r[IDX_W-1:0]];
    end
    if (st_r == ST_CHK) dur_r <= fe_r - fs_r;
    if (st_r == ST_DIV2 && div_done) base_r <= div_q[15:0];
    if (st_r == ST_MUL) begin
      plo_r <= tot_r * d2[16:0];
      phi_r <= tot_r * d2[33:17];
      rp_r  <= after * dur_r;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    out_result_kind    <= KIND_DONE;
    out_flow_index     <= 4'd0;
    out_first_sequence <= 16'd0;
    out_event_count    <= 16'd0;
    out_all_done       <= ended_r;
    out_accepted       <= 1'b0;
    out_last           <= 1'b1;
    unique case (st_r)
      ST_LOAD: begin
        out_result_kind <= KIND_LOAD;
        out_flow_index  <= load_ok ? loaded_r[IDX_W-1:0] : 4'd0;
        out_accepted    <= load_ok;
      end
      ST_CMP: begin
        out_result_kind    <= KIND_EMIT;
        out_flow_index     <= idx_r[IDX_W-1:0];
        out_first_sequence <= iss_r;
        out_event_count    <= cnt_sat;
        out_all_done       <= 1'b0;
        out_last           <= 1'b0;
      end
      default: out_result_kind <= KIND_DONE;
    endcase
  end

endmodule

// ----- src/interval_flow_pacer.sv -----
// channel   ports                                     handshake
// input     in_action in_flow_* in_tick_time          start & !busy
// result    out_result_kind .. out_last               out_strobe, one cycle
// config    cfg_we cfg_index cfg_data                 cfg_we
// a load is popped in ST_IDLE and answered from ST_LOAD by a registered result beat; a tick
// runs two divider passes per active flow, and idle flows pass only ST_NEXT, ST_RD and ST_CHK
// reset clears control state; the flow table holds no valid bits
// a two-beat queue lets items arrive while the back part walks the table
// results cannot be stalled: one beat per strobe
module interval_flow_pacer import ifp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_flow_start,
  input  logic [31:0] in_flow_stop,
  input  logic [15:0] in_flow_total,
  input  logic [31:0] in_tick_time,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_flow_index,
  output logic [15:0] out_first_sequence,
  output logic [15:0] out_event_count,
  output logic        out_all_done,
  output logic        out_accepted,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t in_cmd, q_cmd;
  logic q_valid, pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_begin <= 32'd0;
      cfg_r.window_end   <= 32'hFFFF_FFFF;
      cfg_r.step_length  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIN_BEGIN: cfg_r.window_begin <= cfg_data;
        REG_WIN_END:   cfg_r.window_end   <= cfg_data;
        REG_STEP:      cfg_r.step_length  <= cfg_data[15:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_cmd = '{action: in_action, flow_start: in_flow_start, flow_stop: in_flow_stop,
                    flow_total: in_flow_total, tick_time: in_tick_time};

  ifp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_cmd  (in_cmd),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_cmd   (q_cmd)
  );

  ifp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .pop                (pop),
    .out_strobe         (out_strobe),
    .out_result_kind    (out_result_kind),
    .out_flow_index     (out_flow_index),
    .out_first_sequence (out_first_sequence),
    .out_event_count    (out_event_count),
    .out_all_done       (out_all_done),
    .out_accepted       (out_accepted),
    .out_last           (out_last)
  );

endmodule
